// File: design/lebd_pkg.sv
// ----------------------------------------------------------------------------
// lebd_pkg
// Shared types and constants for the LEB128 stream decoder.
// ----------------------------------------------------------------------------
package lebd_pkg;

    localparam int unsigned ByteW      = 8;
    localparam int unsigned PayloadW   = 7;
    localparam int unsigned ValueW     = 32;
    localparam int unsigned CountW     = 3;
    localparam int unsigned PartialW   = 28;
    localparam int unsigned ActionW    = 2;
    localparam logic [CountW-1:0] LastIdx = 3'd4;

    // Format codes carried by the action field on the first byte of a value.
    typedef enum logic [ActionW-1:0] {
        FMT_UNSIGNED  = 2'd0,
        FMT_SIGNED    = 2'd1,
        FMT_MINUS_ONE = 2'd2
    } t_fmt;

    // Decode result and next state for one byte.
    typedef struct packed {
        logic                  emit;
        logic [ValueW-1:0]     value;
        logic [CountW-1:0]     count;
        logic                  err;
        logic [PartialW-1:0]   next_partial;
        logic [CountW-1:0]     next_bytes;
        t_fmt                  next_fmt;
    } t_dec_out;

endpackage

// File: design/lebd_core.sv
// ----------------------------------------------------------------------------
// lebd_core
// Single-byte decode step: merges one 7-bit group into the partial value,
// finishes a value on a clear top bit or on the fifth byte, applies the
// sign extension or the minus-one adjust.
// ----------------------------------------------------------------------------
module lebd_core (
    input  logic [lebd_pkg::ByteW-1:0]    i_data_byte,
    input  logic [lebd_pkg::ActionW-1:0]  i_action,
    input  logic [lebd_pkg::PartialW-1:0] i_partial,
    input  logic [lebd_pkg::CountW-1:0]   i_bytes_so_far,
    input  lebd_pkg::t_fmt                i_held_format,
    output lebd_pkg::t_dec_out            o_dec
);

    logic [lebd_pkg::CountW-1:0]   k;
    logic                          first;
    logic                          more;
    logic [lebd_pkg::PayloadW-1:0] payload;
    lebd_pkg::t_fmt                fmt;
    logic [lebd_pkg::ValueW-1:0]   base;
    logic [lebd_pkg::ValueW-1:0]   shifted;
    logic [lebd_pkg::ValueW-1:0]   value;
    logic [lebd_pkg::ValueW-1:0]   sext;
    logic                          is_last;
    logic                          err;

    always_comb begin
        k       = (i_bytes_so_far > lebd_pkg::LastIdx) ? lebd_pkg::LastIdx : i_bytes_so_far;
        first   = (k == 3'd0);
        more    = i_data_byte[lebd_pkg::ByteW-1];
        payload = i_data_byte[lebd_pkg::PayloadW-1:0];
        is_last = (k == lebd_pkg::LastIdx);
        err     = more && is_last;

        // Format is latched on the first byte; the spare code decodes as unsigned.
        if (first) begin
            case (i_action)
                lebd_pkg::FMT_SIGNED:    fmt = lebd_pkg::FMT_SIGNED;
                lebd_pkg::FMT_MINUS_ONE: fmt = lebd_pkg::FMT_MINUS_ONE;
                default:                 fmt = lebd_pkg::FMT_UNSIGNED;
            endcase
        end else begin
            fmt = i_held_format;
        end

        base = first ? '0 : {4'b0, i_partial};

        // Place the group; the fifth byte keeps only its low four bits.
        case (k)
            3'd0:    shifted = {25'b0, payload};
            3'd1:    shifted = {18'b0, payload, 7'b0};
            3'd2:    shifted = {11'b0, payload, 14'b0};
            3'd3:    shifted = {4'b0, payload, 21'b0};
            default: shifted = {payload[3:0], 28'b0};
        endcase
        value = base | shifted;

        // Sign-extend from the top bit of the last group.
        case (k)
            3'd0:    sext = {{25{value[6]}}, value[6:0]};
            3'd1:    sext = {{18{value[13]}}, value[13:0]};
            3'd2:    sext = {{11{value[20]}}, value[20:0]};
            3'd3:    sext = {{4{value[27]}}, value[27:0]};
            default: sext = value;
        endcase

        o_dec.emit  = !more || is_last;
        o_dec.count = k + 3'd1;
        o_dec.err   = err;
        if (fmt == lebd_pkg::FMT_SIGNED) begin
            o_dec.value = sext;
        end else if (fmt == lebd_pkg::FMT_MINUS_ONE && !err) begin
            o_dec.value = value - 32'd1;
        end else begin
            o_dec.value = value;
        end

        // Advance on a continued byte, drop back to the start otherwise.
        if (o_dec.emit) begin
            o_dec.next_partial = '0;
            o_dec.next_bytes   = '0;
        end else begin
            o_dec.next_partial = value[lebd_pkg::PartialW-1:0];
            o_dec.next_bytes   = k + 3'd1;
        end
        o_dec.next_fmt = fmt;
    end

endmodule

// File: design/leb128_stream_decoder.sv
// ----------------------------------------------------------------------------
// leb128_stream_decoder
// Decodes a stream of 32-bit LEB128 values, one byte per request.
// ----------------------------------------------------------------------------
// One byte request is taken every cycle while the output side is not stalled.
// Each byte is captured in an input register, decoded in a single step against
// the held partial value, and a finished value moves from the input register
// into the result register once the result side is free.
// A stalled result holds the input register, which then stalls the byte side.
// Continuation bytes before the fifth produce no result. A value ends on a
// byte with a clear top bit or on its fifth byte; a fifth byte that still
// has its top bit set raises o_overlong_error.
// The format (unsigned, signed, unsigned minus one) comes from i_action on
// the first byte of each value.
module leb128_stream_decoder (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic [lebd_pkg::ByteW-1:0]     i_data_byte,
    input  logic [lebd_pkg::ActionW-1:0]   i_action,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic [lebd_pkg::ValueW-1:0]    o_decoded_value,
    output logic [lebd_pkg::CountW-1:0]    o_byte_count,
    output logic                           o_overlong_error
);

    logic                          r_in_valid;
    logic [lebd_pkg::ByteW-1:0]    r_byte;
    logic [lebd_pkg::ActionW-1:0]  r_action;
    logic [lebd_pkg::PartialW-1:0] r_partial;
    logic [lebd_pkg::CountW-1:0]   r_bytes;
    lebd_pkg::t_fmt                r_fmt;
    logic                          r_out_valid;
    logic [lebd_pkg::ValueW-1:0]   r_value;
    logic [lebd_pkg::CountW-1:0]   r_count;
    logic                          r_err;

    lebd_pkg::t_dec_out            dec;
    logic                          out_free;
    logic                          advance;
    logic                          in_take;

    lebd_core u_core (
        .i_data_byte   (r_byte),
        .i_action      (r_action),
        .i_partial     (r_partial),
        .i_bytes_so_far(r_bytes),
        .i_held_format (r_fmt),
        .o_dec         (dec)
    );

    assign out_free   = !r_out_valid || !i_out_stall;
    assign advance    = r_in_valid && out_free;
    assign o_in_stall = r_in_valid && !advance;
    assign in_take    = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_partial   <= '0;
            r_bytes     <= '0;
            r_fmt       <= lebd_pkg::FMT_UNSIGNED;
            r_out_valid <= 1'b0;
        end else begin
            if (in_take) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_partial <= dec.next_partial;
                r_bytes   <= dec.next_bytes;
                r_fmt     <= dec.next_fmt;
            end
            if (advance && dec.emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers: no reset needed.
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_byte   <= i_data_byte;
            r_action <= i_action;
        end
        if (advance && dec.emit) begin
            r_value <= dec.value;
            r_count <= dec.count;
            r_err   <= dec.err;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_decoded_value  = r_value;
    assign o_byte_count     = r_count;
    assign o_overlong_error = r_err;

endmodule
